// ----- hw/rtl/cwas_pkg.sv -----
// Shared types and constants for the clock with alarm slots block.
`timescale 1ns / 1ps
package cwas_pkg;

  localparam int unsigned SLOTS_DEF  = 8;
  localparam int unsigned SEC_MAX    = 59;
  localparam int unsigned MIN_MAX    = 59;
  localparam int unsigned HOUR_MAX   = 23;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_ADD  = 2'd2,
    ACT_DEL  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_STAT,
    S_EMIT
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [14:0] alarm_id;
  } in_t;

  typedef struct packed {
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    status_e     status;
    logic        alarm_fired;
    logic [14:0] fired_id;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } time_t;

  // Flags the clock counter raises for the word being accepted.
  typedef struct packed {
    logic wrap;       // tick rolls the seconds over
    logic range_err;  // set time holds an out-of-range field
  } time_evt_t;

  typedef struct packed {
    logic [14:0] id;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } slot_t;

endpackage

// ----- hw/rtl/cwas_time.sv -----
// Time-of-day counter: tick and load of seconds, minutes and hours.
`timescale 1ns / 1ps
module cwas_time
  import cwas_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_t       item_i,
  output time_t     time_o,
  output time_evt_t evt_o
);

  logic [5:0] sec_q, sec_d;
  logic [5:0] min_q, min_d;
  logic [4:0] hour_q, hour_d;

  always_comb begin
    evt_o.wrap      = (item_i.action == ACT_TICK) && (sec_q >= 6'(SEC_MAX));
    evt_o.range_err = (item_i.in_hour > 5'(HOUR_MAX)) || (item_i.in_minute > 6'(MIN_MAX)) ||
                      (item_i.in_second > 6'(SEC_MAX));
  end

  always_comb begin
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    if (accept_i) begin
      case (item_i.action)
        ACT_TICK: begin
          if (sec_q >= 6'(SEC_MAX)) begin
            sec_d = '0;
            if (min_q >= 6'(MIN_MAX)) begin
              min_d  = '0;
              hour_d = (hour_q >= 5'(HOUR_MAX)) ? '0 : hour_q + 5'd1;
            end else begin
              min_d = min_q + 6'd1;
            end
          end else begin
            sec_d = sec_q + 6'd1;
          end
        end
        ACT_SET: begin
          if (!evt_o.range_err) begin
            sec_d  = item_i.in_second;
            min_d  = item_i.in_minute;
            hour_d = item_i.in_hour;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
    end else begin
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
    end
  end

  assign time_o = '{hour: hour_q, minute: min_q, second: sec_q};

endmodule

// ----- hw/rtl/cwas_slot_ram.sv -----
// Alarm slot store: id, hour and minute per slot, registered read.
`timescale 1ns / 1ps
module cwas_slot_ram
  import cwas_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = SLOTS_DEF,
  localparam int unsigned PtrW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [PtrW-1:0] waddr_i,
  input  slot_t           wdata_i,
  input  logic [PtrW-1:0] raddr_i,
  output slot_t           rdata_o
);

  slot_t mem_q [ALARM_SLOTS];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/cwas_ctrl.sv -----
// Sequencer: walks the slots for add, delete and alarm match, then emits results.
`timescale 1ns / 1ps
module cwas_ctrl
  import cwas_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = SLOTS_DEF,
  localparam int unsigned PtrW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1,
  localparam int unsigned CntW = $clog2(ALARM_SLOTS + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  in_t             item_i,
  input  time_t           time_i,
  input  time_evt_t       evt_i,
  output logic            ram_we_o,
  output logic [PtrW-1:0] ram_waddr_o,
  output slot_t           ram_wdata_o,
  output logic [PtrW-1:0] ram_raddr_o,
  input  slot_t           ram_rdata_i,
  output logic            result_valid_o,
  output out_t            result_o
);

  state_e                 state_q, state_d;
  in_t                    item_q, item_d;
  status_e                status_q, status_d;
  logic [ALARM_SLOTS-1:0] valid_q, valid_d;
  logic [ALARM_SLOTS-1:0] fire_q, fire_d;
  logic [ALARM_SLOTS-1:0] fire_rest;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [PtrW-1:0]        cmp_ptr_q, cmp_ptr_d;
  logic                   out_vld_q, out_vld_d;
  out_t                   out_q, out_d;
  logic                   accept;
  logic                   rd_done;
  logic [PtrW-1:0]        ptr;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign rd_done = (cnt_q == CntW'(ALARM_SLOTS));
  assign ptr     = cnt_q[PtrW-1:0];

  assign ram_raddr_o = ptr;
  assign ram_waddr_o = ptr;
  assign ram_wdata_o = '{id: item_q.alarm_id, hour: item_q.in_hour, minute: item_q.in_minute};

  always_comb begin
    fire_rest            = fire_q;
    fire_rest[cmp_ptr_q] = 1'b0;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (item_i.action)
            ACT_TICK: state_d = evt_i.wrap ? S_SCAN : S_STAT;
            ACT_SET:  state_d = S_STAT;
            ACT_ADD:  state_d = S_ADD;
            ACT_DEL:  state_d = S_SCAN;
            default:  state_d = S_STAT;
          endcase
        end
      end
      S_ADD: begin
        if (rd_done || !valid_q[ptr]) state_d = S_STAT;
      end
      S_SCAN: begin
        if (rd_done) state_d = S_STAT;
      end
      S_STAT: begin
        state_d = (fire_q != '0) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (rd_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    item_d    = item_q;
    status_d  = status_q;
    valid_d   = valid_q;
    fire_d    = fire_q;
    cnt_d     = cnt_q;
    cmp_vld_d = cmp_vld_q;
    cmp_ptr_d = cmp_ptr_q;
    out_vld_d = 1'b0;
    out_d     = out_q;
    ram_we_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d    = item_i;
          fire_d    = '0;
          cnt_d     = '0;
          cmp_vld_d = 1'b0;
          status_d  = ((item_i.action == ACT_SET) && evt_i.range_err) ? ST_RANGE : ST_OK;
        end
      end
      S_ADD: begin
        if (rd_done) begin
          status_d = ST_FULL;
        end else if (!valid_q[ptr]) begin
          ram_we_o     = 1'b1;
          valid_d[ptr] = 1'b1;
          status_d     = ST_OK;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      S_SCAN, S_EMIT: begin
        // Issue the next read; compare the word read last cycle.
        if (!rd_done) begin
          cnt_d     = cnt_q + CntW'(1);
          cmp_vld_d = 1'b1;
          cmp_ptr_d = ptr;
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q) begin
          if (state_q == S_SCAN) begin
            if (item_q.action == ACT_DEL) begin
              if (valid_q[cmp_ptr_q] && (ram_rdata_i.id == item_q.alarm_id)) begin
                valid_d[cmp_ptr_q] = 1'b0;
              end
            end else begin
              if (valid_q[cmp_ptr_q] && (ram_rdata_i.hour == time_i.hour) &&
                  (ram_rdata_i.minute == time_i.minute)) begin
                fire_d[cmp_ptr_q] = 1'b1;
              end
            end
          end else if (fire_q[cmp_ptr_q]) begin
            out_vld_d         = 1'b1;
            out_d             = '{cur_hour: time_i.hour, cur_minute: time_i.minute,
                                  cur_second: time_i.second, status: ST_OK,
                                  alarm_fired: 1'b1, fired_id: ram_rdata_i.id,
                                  last: (fire_rest == '0)};
            fire_d[cmp_ptr_q] = 1'b0;
          end
        end
      end
      S_STAT: begin
        out_vld_d = 1'b1;
        out_d     = '{cur_hour: time_i.hour, cur_minute: time_i.minute,
                      cur_second: time_i.second, status: status_q,
                      alarm_fired: 1'b0, fired_id: '0, last: (fire_q == '0)};
        cnt_d     = '0;
        cmp_vld_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      fire_q    <= '0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      status_q  <= ST_OK;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      fire_q    <= fire_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    cmp_ptr_q <= cmp_ptr_d;
    out_q     <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

// ----- hw/rtl/clock_with_alarm_slots_unit.sv -----
// Top level: time-of-day clock with a table of alarm slots.
//
//   channel   ports                          handshake
//   command   start, item_i (in_t)           taken when start && !busy
//   result    result_valid_o, result_o       one-cycle strobe, cannot be held off
//
// Tick without minute change and set time do no table walk; add stops at the first
// empty slot; delete and a tick that rolls the seconds over walk the whole table, and
// the tick walks it again when at least one alarm fires.
// One slot read port walks the table once to find matches and once more to read
// the fired ids; each result is registered and appears in the cycle after the state that makes it.
// Reset clears the clock to midnight and marks every slot empty.
// The receiver takes every result in the cycle it is shown.
`timescale 1ns / 1ps
module clock_with_alarm_slots_unit
  import cwas_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic result_valid_o,
  output out_t result_o
);

  localparam int unsigned PtrW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  time_t           cur_time;
  time_evt_t       time_evt;
  logic            ram_we;
  logic [PtrW-1:0] ram_waddr;
  logic [PtrW-1:0] ram_raddr;
  slot_t           ram_wdata;
  slot_t           ram_rdata;

  cwas_time u_time (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !busy),
    .item_i   (item_i),
    .time_o   (cur_time),
    .evt_o    (time_evt)
  );

  cwas_slot_ram #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cwas_ctrl #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .time_i         (cur_time),
    .evt_i          (time_evt),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- tb/tb_clock_with_alarm_slots_unit.sv -----
// Self-checking testbench for the clock with alarm slots block: directed, then random words.
`timescale 1ns / 1ps
module tb_clock_with_alarm_slots_unit
  import cwas_pkg::*;
();

  localparam int unsigned N_SLOTS     = SLOTS_DEF;
  localparam int unsigned RANDOM_WORDS = 85;

  // Tracks the clock and the slot table; holds the results still due from the block.
  class alarm_clock_scoreboard;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    bit          slot_valid [N_SLOTS];
    logic [14:0] slot_id    [N_SLOTS];
    logic [4:0]  slot_hour  [N_SLOTS];
    logic [5:0]  slot_minute[N_SLOTS];
    out_t        pending_results[$];
    int          mismatches;

    function new();
      hour       = '0;
      minute     = '0;
      second     = '0;
      mismatches = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function out_t time_result(status_e st, logic fired, logic [14:0] id, logic lst);
      out_t r;
      r.cur_hour    = hour;
      r.cur_minute  = minute;
      r.cur_second  = second;
      r.status      = st;
      r.alarm_fired = fired;
      r.fired_id    = id;
      r.last        = lst;
      return r;
    endfunction

    // Advance the model by one accepted word and queue what the block must return.
    function void note_word(in_t w);
      bit      fire[N_SLOTS];
      int      nfired;
      int      k;
      bit      stored;
      status_e st;
      st     = ST_OK;
      nfired = 0;
      stored = 1'b0;
      foreach (fire[i]) fire[i] = 1'b0;
      case (w.action)
        ACT_TICK: begin
          if (second >= SEC_MAX) begin
            second = '0;
            if (minute >= MIN_MAX) begin
              minute = '0;
              hour   = (hour >= HOUR_MAX) ? 5'd0 : hour + 5'd1;
            end else begin
              minute = minute + 6'd1;
            end
            for (int i = 0; i < N_SLOTS; i++) begin
              if (slot_valid[i] && slot_hour[i] == hour && slot_minute[i] == minute) begin
                fire[i] = 1'b1;
                nfired++;
              end
            end
          end else begin
            second = second + 6'd1;
          end
        end
        ACT_SET: begin
          if (w.in_hour > HOUR_MAX || w.in_minute > MIN_MAX || w.in_second > SEC_MAX) begin
            st = ST_RANGE;
          end else begin
            hour   = w.in_hour;
            minute = w.in_minute;
            second = w.in_second;
          end
        end
        ACT_ADD: begin
          // First empty slot takes the alarm, range unchecked.
          for (int i = 0; i < N_SLOTS; i++) begin
            if (!stored && !slot_valid[i]) begin
              slot_valid[i]  = 1'b1;
              slot_id[i]     = w.alarm_id;
              slot_hour[i]   = w.in_hour;
              slot_minute[i] = w.in_minute;
              stored         = 1'b1;
            end
          end
          st = stored ? ST_OK : ST_FULL;
        end
        default: begin
          for (int i = 0; i < N_SLOTS; i++) begin
            if (slot_valid[i] && slot_id[i] == w.alarm_id) slot_valid[i] = 1'b0;
          end
        end
      endcase
      pending_results.push_back(time_result(st, 1'b0, '0, nfired == 0));
      k = 1;
      for (int i = 0; i < N_SLOTS; i++) begin
        if (fire[i]) begin
          pending_results.push_back(time_result(ST_OK, 1'b1, slot_id[i], k == nfired));
          k++;
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none actual %0h", $time, got);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("cur_hour",    32'(exp_r.cur_hour),    32'(got.cur_hour));
      compare_field("cur_minute",  32'(exp_r.cur_minute),  32'(got.cur_minute));
      compare_field("cur_second",  32'(exp_r.cur_second),  32'(got.cur_second));
      compare_field("status",      32'(exp_r.status),      32'(got.status));
      compare_field("alarm_fired", 32'(exp_r.alarm_fired), 32'(got.alarm_fired));
      compare_field("fired_id",    32'(exp_r.fired_id),    32'(got.fired_id));
      compare_field("last",        32'(exp_r.last),        32'(got.last));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  item_i;
  logic result_valid_o;
  out_t result_o;

  alarm_clock_scoreboard sb = new();
  bit burst;

  clock_with_alarm_slots_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Check results before noting the word taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start && !busy) sb.note_word(item_i);
    end
  end

  function automatic in_t make_word(action_e a, int h, int m, int s, int id);
    in_t w;
    w.action    = a;
    w.in_hour   = 5'(h);
    w.in_minute = 6'(m);
    w.in_second = 6'(s);
    w.alarm_id  = 15'(id);
    return w;
  endfunction

  // Mostly well-formed traffic: times near a minute rollover, alarms due at the next minute.
  function automatic in_t random_word();
    in_t w;
    int  pick;
    int  k;
    w.action    = ACT_TICK;
    w.in_hour   = 5'($urandom);
    w.in_minute = 6'($urandom);
    w.in_second = 6'($urandom);
    w.alarm_id  = 15'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.action = ACT_TICK;
    end else if (pick < 60) begin
      w.action = ACT_SET;
      if ($urandom_range(0, 4) != 0) begin
        w.in_hour   = 5'($urandom_range(0, HOUR_MAX));
        w.in_minute = 6'($urandom_range(0, MIN_MAX));
        w.in_second = 6'($urandom_range(SEC_MAX - 4, SEC_MAX));
      end
    end else if (pick < 82) begin
      w.action = ACT_ADD;
      if ($urandom_range(0, 3) != 0) begin
        if (sb.minute >= MIN_MAX) begin
          w.in_minute = '0;
          w.in_hour   = (sb.hour >= HOUR_MAX) ? 5'd0 : sb.hour + 5'd1;
        end else begin
          w.in_minute = sb.minute + 6'd1;
          w.in_hour   = sb.hour;
        end
      end
    end else begin
      w.action = ACT_DEL;
      k = $urandom_range(0, N_SLOTS - 1);
      if (sb.slot_valid[k] && $urandom_range(0, 3) != 0) w.alarm_id = sb.slot_id[k];
    end
    return w;
  endfunction

  // Hold the word on the bus until an edge with busy low takes it.
  task automatic send_word(input in_t w, input bit draw_random);
    int gap;
    if ($urandom_range(0, 9) == 0) burst = ~burst;
    gap = burst ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    if (draw_random) w = random_word();
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    start  = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    burst  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(make_word(ACT_TICK, 0, 0, 0, 0), 1'b0);
    send_word(make_word(ACT_ADD, 0, 1, 0, 'h7FFF), 1'b0);
    send_word(make_word(ACT_SET, 0, 0, 59, 0), 1'b0);
    send_word(make_word(ACT_TICK, 0, 0, 0, 0), 1'b0);
    // out-of-range set times leave the clock alone
    send_word(make_word(ACT_SET, 24, 0, 0, 0), 1'b0);
    send_word(make_word(ACT_SET, 0, 60, 0, 0), 1'b0);
    send_word(make_word(ACT_SET, 0, 0, 60, 0), 1'b0);
    send_word(make_word(ACT_SET, 31, 63, 63, 'h7FFF), 1'b0);
    send_word(make_word(ACT_SET, 23, 59, 58, 0), 1'b0);
    send_word(make_word(ACT_ADD, 0, 0, 0, 0), 1'b0);
    send_word(make_word(ACT_ADD, 31, 63, 63, 'h5555), 1'b0);
    send_word(make_word(ACT_ADD, 0, 0, 0, 'h2AAA), 1'b0);
    send_word(make_word(ACT_TICK, 0, 0, 0, 0), 1'b0);
    send_word(make_word(ACT_TICK, 0, 0, 0, 0), 1'b0);
    // fill the table, then overflow it
    send_word(make_word(ACT_ADD, 0, 0, 0, 'h2AAA), 1'b0);
    send_word(make_word(ACT_ADD, 0, 0, 0, 1), 1'b0);
    send_word(make_word(ACT_ADD, 0, 0, 0, 2), 1'b0);
    send_word(make_word(ACT_ADD, 0, 0, 0, 3), 1'b0);
    send_word(make_word(ACT_ADD, 12, 30, 0, 4), 1'b0);
    send_word(make_word(ACT_DEL, 0, 0, 0, 'h2AAA), 1'b0);
    send_word(make_word(ACT_DEL, 0, 0, 0, 'h1234), 1'b0);
    send_word(make_word(ACT_ADD, 0, 1, 0, 'h7FFF), 1'b0);
    send_word(make_word(ACT_SET, 0, 0, 59, 0), 1'b0);
    send_word(make_word(ACT_TICK, 0, 0, 0, 0), 1'b0);
    send_word(make_word(ACT_DEL, 0, 0, 0, 'h7FFF), 1'b0);

    for (int n = 0; n < RANDOM_WORDS; n++) send_word('0, 1'b1);
    @(negedge clk_i);
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * N_SLOTS + 8) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
